// ----- rtl/core/integer_to_ascii_radix_unit_defines.svh -----
// Assertion macros shared by the integer to ASCII radix unit
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`endif

// ----- rtl/core/i2a_pkg.sv -----
// Types, character constants and helper functions of the integer to ASCII unit
`default_nettype none

package i2a_pkg;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    localparam logic [5:0] RADIX_BIN = 6'd2;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [5:0] RADIX_HEX = 6'd16;

    typedef enum logic [2:0] {
        RAD_BIN,
        RAD_OCT,
        RAD_DEC,
        RAD_HEX,
        RAD_BAD
    } t_radix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_HAND
    } t_state;

    // Hand-off from the sequencer to the emitter
    typedef struct packed {
        logic   go;
        t_radix kind;
        logic   neg;
    } t_emit_load;

    // Decimal digits needed for a w-bit magnitude (301/1000 ~ log10(2))
    function automatic int dec_digits(input int w);
        return (w * 301) / 1000 + 1;
    endfunction

    function automatic t_radix radix_kind(input logic [5:0] radix);
        t_radix kind;
        case (radix)
            RADIX_BIN: kind = RAD_BIN;
            RADIX_OCT: kind = RAD_OCT;
            RADIX_DEC: kind = RAD_DEC;
            RADIX_HEX: kind = RAD_HEX;
            default:   kind = RAD_BAD;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/i2a_in_if.sv -----
// Input channel of the integer to ASCII unit: value and radix
`default_nettype none

interface i2a_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [5:0]             radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/i2a_out_if.sv -----
// Output channel of the integer to ASCII unit: one character per item
`default_nettype none

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;
    logic       bad_radix;

    modport source (output valid, output char_code, output last, output bad_radix, input ready);
    modport sink   (input valid, input char_code, input last, input bad_radix, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/i2a_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle
`default_nettype none

module i2a_dabble #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                                 i_clk,
    input  wire logic                                                 i_rst_n,
    input  wire logic                                                 i_start,
    input  wire logic [VALUE_WIDTH-1:0]                               i_mag,
    output logic                                                      o_busy,
    output logic [4*i2a_pkg::dec_digits(VALUE_WIDTH)-1:0]             o_bcd
);
    localparam int NDIG  = i2a_pkg::dec_digits(VALUE_WIDTH);
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy, n_busy;
    logic [CNT_W-1:0]       r_cnt,  n_cnt;
    logic [VALUE_WIDTH-1:0] r_bin,  n_bin;
    logic [BCD_W-1:0]       r_bcd,  n_bcd;
    logic [BCD_W-1:0]       w_adj;

    // Correct every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_WIDTH);
            n_bin  = i_mag;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

// ----- rtl/core/i2a_emit.sv -----
// Digit emitter: shifts digits out most significant first, drops leading zeros
`default_nettype none

module i2a_emit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire i2a_pkg::t_emit_load                           i_load,
    input  wire logic [4*i2a_pkg::dec_digits(VALUE_WIDTH)-1:0] i_word,
    input  wire logic [$clog2(VALUE_WIDTH+1)-1:0]              i_cnt,
    output logic                                               o_busy,
    i2a_out_if.source                                          o_out
);
    localparam int EW    = 4 * i2a_pkg::dec_digits(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic              r_busy, n_busy;
    logic [EW-1:0]     r_sh,   n_sh;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    i2a_pkg::t_radix   r_kind, n_kind;
    logic              r_neg,  n_neg;
    logic              r_lead, n_lead;
    logic              r_oval, n_oval;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic              r_bad,  n_bad;

    logic              w_free;
    logic [3:0]        w_digit;
    logic [EW-1:0]     w_shifted;
    logic [7:0]        w_char;

    // Top digit and the word after it is consumed
    always_comb begin
        case (r_kind)
            i2a_pkg::RAD_BIN: begin
                w_digit   = {3'b000, r_sh[EW-1]};
                w_shifted = r_sh << 1;
            end
            i2a_pkg::RAD_OCT: begin
                w_digit   = {1'b0, r_sh[EW-1 -: 3]};
                w_shifted = r_sh << 3;
            end
            default: begin
                w_digit   = r_sh[EW-1 -: 4];
                w_shifted = r_sh << 4;
            end
        endcase
        w_char = (w_digit < 4'd10) ? i2a_pkg::CHAR_ZERO + {4'b0000, w_digit}
                                   : i2a_pkg::CHAR_UPPER_A + {4'b0000, w_digit} - 8'd10;
    end

    always_comb begin
        n_busy = r_busy;
        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_kind = r_kind;
        n_neg  = r_neg;
        n_lead = r_lead;
        n_oval = r_oval;
        n_char = r_char;
        n_last = r_last;
        n_bad  = r_bad;
        w_free = !r_oval || o_out.ready;
        if (r_oval && o_out.ready) begin
            n_oval = 1'b0;
        end
        if (i_load.go) begin
            n_busy = 1'b1;
            n_sh   = i_word;
            n_cnt  = i_cnt;
            n_kind = i_load.kind;
            n_neg  = i_load.neg;
            n_lead = 1'b1;
        end else if (r_busy) begin
            if (r_kind == i2a_pkg::RAD_BAD) begin
                if (w_free) begin
                    n_oval = 1'b1;
                    n_char = i2a_pkg::CHAR_NONE;
                    n_last = 1'b1;
                    n_bad  = 1'b1;
                    n_busy = 1'b0;
                end
            end else if (r_neg) begin
                if (w_free) begin
                    n_oval = 1'b1;
                    n_char = i2a_pkg::CHAR_MINUS;
                    n_last = 1'b0;
                    n_bad  = 1'b0;
                    n_neg  = 1'b0;
                end
            end else if (r_lead && (w_digit == 4'd0) && (r_cnt > CNT_W'(1))) begin
                n_sh  = w_shifted;
                n_cnt = r_cnt - CNT_W'(1);
            end else if (w_free) begin
                n_oval = 1'b1;
                n_char = w_char;
                n_last = (r_cnt == CNT_W'(1));
                n_bad  = 1'b0;
                n_sh   = w_shifted;
                n_cnt  = r_cnt - CNT_W'(1);
                n_lead = 1'b0;
                if (r_cnt == CNT_W'(1)) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_cnt  <= n_cnt;
        r_kind <= n_kind;
        r_neg  <= n_neg;
        r_lead <= n_lead;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    assign o_busy          = r_busy;
    assign o_out.valid     = r_oval;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;
    assign o_out.bad_radix = r_bad;

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_ascii_radix_unit.sv -----
// Top level of the integer to ASCII unit: sequencer, BCD converter and emitter
//
// Usage:
//   i_in carries one signed VALUE_WIDTH-bit value and a 6-bit radix per item.
//   o_out returns the ASCII characters most significant first, one per item,
//   with last set on the final one. Radix 10 prints '-' and the magnitude for
//   a negative value; radix 2, 8 and 16 print the raw bit pattern with A-F.
//   Any other radix returns one item with bad_radix set and char_code 0.
// Flow:
//   Radix 10 runs the shift-and-add-3 converter one bit per cycle over all
//   VALUE_WIDTH bits; the sequencer then sees it finish and hands the
//   digits over to the emitter. Other radixes skip the converter and are
//   handed over once the emitter is free. The emitter gives a sign first,
//   then steps through every digit position, dropped leading zeros
//   included. The sequencer takes a new item once it has handed the last
//   one over, so conversion overlaps the previous output.
// Reset: synchronous, active low; clears the sequencer and all valid flags.
// Stall: a low o_out.ready holds the output register; zero dropping goes on.
`default_nettype none
`include "integer_to_ascii_radix_unit_defines.svh"

module integer_to_ascii_radix_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);
    localparam int NDIG  = i2a_pkg::dec_digits(VALUE_WIDTH);
    localparam int EW    = 4 * NDIG;
    localparam int HEXD  = (VALUE_WIDTH + 3) / 4;
    localparam int OCTD  = (VALUE_WIDTH + 2) / 3;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    i2a_pkg::t_state        r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag,   n_mag;
    i2a_pkg::t_radix        r_kind,  n_kind;
    logic                   r_neg,   n_neg;

    logic                   w_accept;
    logic                   w_ready;
    logic                   w_dab_start;
    logic                   w_in_neg;
    i2a_pkg::t_radix        w_in_kind;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [VALUE_WIDTH-1:0] w_in_mag;
    logic                   w_dab_busy;
    logic [EW-1:0]          w_bcd;
    logic                   w_emit_busy;
    i2a_pkg::t_emit_load    w_load;
    logic [EW-1:0]          w_word;
    logic [CNT_W-1:0]       w_cnt;

    // Decode the incoming item
    assign w_in_val  = i_in.value;
    assign w_in_kind = i2a_pkg::radix_kind(i_in.radix);
    assign w_in_neg  = (w_in_kind == i2a_pkg::RAD_DEC) && w_in_val[VALUE_WIDTH-1];
    assign w_in_mag  = w_in_neg ? (~w_in_val + VALUE_WIDTH'(1)) : w_in_val;
    assign w_accept  = i_in.valid && w_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (w_in_kind == i2a_pkg::RAD_DEC) ? i2a_pkg::ST_CONV
                                                              : i2a_pkg::ST_HAND;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (!w_dab_busy) begin
                    n_state = i2a_pkg::ST_HAND;
                end
            end
            i2a_pkg::ST_HAND: begin
                if (!w_emit_busy) begin
                    n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: n_state = i2a_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_ready     = 1'b0;
        w_dab_start = 1'b0;
        w_load.go   = 1'b0;
        w_load.kind = r_kind;
        w_load.neg  = r_neg;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                w_ready     = 1'b1;
                w_dab_start = i_in.valid && (w_in_kind == i2a_pkg::RAD_DEC);
            end
            i2a_pkg::ST_HAND: begin
                w_load.go = !w_emit_busy;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    // Latch the magnitude and radix class of an accepted item
    always_comb begin
        n_mag  = r_mag;
        n_kind = r_kind;
        n_neg  = r_neg;
        if (w_accept) begin
            n_mag  = w_in_mag;
            n_kind = w_in_kind;
            n_neg  = w_in_neg;
        end
    end

    // Left-align the digits for the emitter and give their count
    always_comb begin
        case (r_kind)
            i2a_pkg::RAD_DEC: begin
                w_word = w_bcd;
                w_cnt  = CNT_W'(NDIG);
            end
            i2a_pkg::RAD_HEX: begin
                w_word = EW'(r_mag) << (EW - 4 * HEXD);
                w_cnt  = CNT_W'(HEXD);
            end
            i2a_pkg::RAD_OCT: begin
                w_word = EW'(r_mag) << (EW - 3 * OCTD);
                w_cnt  = CNT_W'(OCTD);
            end
            i2a_pkg::RAD_BIN: begin
                w_word = EW'(r_mag) << (EW - VALUE_WIDTH);
                w_cnt  = CNT_W'(VALUE_WIDTH);
            end
            default: begin
                w_word = '0;
                w_cnt  = CNT_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_kind <= n_kind;
        r_neg  <= n_neg;
    end

    assign i_in.ready = w_ready;

    i2a_dabble #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dab_start),
        .i_mag   (w_in_mag),
        .o_busy  (w_dab_busy),
        .o_bcd   (w_bcd)
    );

    i2a_emit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_word  (w_word),
        .i_cnt   (w_cnt),
        .o_busy  (w_emit_busy),
        .o_out   (o_out)
    );

    // An accepted item always leaves the idle state
    `I2A_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != i2a_pkg::ST_IDLE)
    // A hand-off to a free emitter makes it busy in the next cycle
    `I2A_ASSERT_NEXT(a_hand_loads_emitter, i_clk, i_rst_n, w_load.go, w_emit_busy)
    // The converter is never running while the sequencer is idle
    `I2A_ASSERT_NOW(a_idle_conv_quiet, i_clk, i_rst_n, r_state == i2a_pkg::ST_IDLE, !w_dab_busy)

endmodule

`default_nettype wire
